[hdl/bgd_pkg.sv]
// Package: shared types and constants for the button gesture detector.
`timescale 1ns / 1ps

package bgd_pkg;

  localparam int unsigned TIME_WIDTH = 32;
  localparam int unsigned TICK_WIDTH = 16;
  localparam int unsigned ADDR_WIDTH = 4;
  localparam int unsigned DATA_WIDTH = 32;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [TICK_WIDTH-1:0] ticks_t;

  typedef enum logic [1:0] {
    GEST_SHORT  = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_LSTART = 2'd2,
    GEST_LEND   = 2'd3
  } gesture_e;

  typedef enum logic [1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_DOUBLE_CLICK = 2'd1,
    REG_POLL_PERIOD  = 2'd2,
    REG_SINGLE_KEY   = 2'd3
  } reg_idx_e;

  localparam ticks_t LONG_PRESS_RESET   = 16'd500;
  localparam ticks_t DOUBLE_CLICK_RESET = 16'd250;
  localparam ticks_t POLL_PERIOD_RESET  = 16'd50;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_EDGE = 1'b1;

endpackage

[hdl/button_gesture_detector.sv]
// Top level: classifies button edges and ticks into click and long-press gestures.
// Pipeline: an accepted transaction is registered in the input stage, then classified;
// its result is registered in the result register that drives the master side.
// Throughput: one transaction per cycle, limited only by master-side backpressure.
// Reset: asynchronous, active low; clears time, press and click state, and loads
// register defaults (long 500, double 250, poll 50 ticks, single-key mode on).
`timescale 1ns / 1ps

module button_gesture_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] pin_level, [7:1] zero
  input  logic        s_axis_tuser_i,   // [0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [1:0] gesture, [7:2] zero
);

  import bgd_pkg::*;

  logic     long_cfg_we, cfg_we;
  ticks_t   long_ticks_q, dbl_ticks_q, poll_ticks_q;
  logic     single_key_q;

  logic     in_vld_q, in_action_q, in_level_q;
  logic     advance;

  time_t    time_now_q, time_now_d;
  ticks_t   poll_div_q, poll_div_d;
  time_t    press_time_q, press_time_d;
  time_t    pending_time_q, pending_time_d;
  logic     is_pressed_q, is_pressed_d;
  logic     long_rep_q, long_rep_d;
  logic     click_pend_q, click_pend_d;

  logic     res_vld;
  gesture_e res_gest;
  logic     out_vld_q;
  gesture_e out_gest_q;

  // configuration port
  assign pready_o    = 1'b1;
  assign cfg_we      = psel_i & penable_i & pwrite_i & pready_o;
  assign long_cfg_we = cfg_we && (reg_idx_e'(paddr_i[3:2]) == REG_LONG_PRESS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q <= LONG_PRESS_RESET;
      dbl_ticks_q  <= DOUBLE_CLICK_RESET;
      poll_ticks_q <= POLL_PERIOD_RESET;
      single_key_q <= 1'b1;
    end else begin
      if (long_cfg_we) begin
        long_ticks_q <= pwdata_i[TICK_WIDTH-1:0];
      end
      if (cfg_we) begin
        unique case (reg_idx_e'(paddr_i[3:2]))
          REG_DOUBLE_CLICK: dbl_ticks_q  <= pwdata_i[TICK_WIDTH-1:0];
          REG_POLL_PERIOD:  poll_ticks_q <= pwdata_i[TICK_WIDTH-1:0];
          REG_SINGLE_KEY:   single_key_q <= pwdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr_i[3:2]))
      REG_LONG_PRESS:   prdata_o = {{(DATA_WIDTH-TICK_WIDTH){1'b0}}, long_ticks_q};
      REG_DOUBLE_CLICK: prdata_o = {{(DATA_WIDTH-TICK_WIDTH){1'b0}}, dbl_ticks_q};
      REG_POLL_PERIOD:  prdata_o = {{(DATA_WIDTH-TICK_WIDTH){1'b0}}, poll_ticks_q};
      REG_SINGLE_KEY:   prdata_o = {{(DATA_WIDTH-1){1'b0}}, single_key_q};
      default:          prdata_o = '0;
    endcase
  end

  // handshake
  assign advance         = in_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_action_q <= s_axis_tuser_i;
      in_level_q  <= s_axis_tdata_i[0];
    end
  end

  // classification
  always_comb begin
    time_t  t_next;
    ticks_t div_next;
    time_t  press_el;
    time_t  pend_el;

    time_now_d     = time_now_q;
    poll_div_d     = poll_div_q;
    press_time_d   = press_time_q;
    pending_time_d = pending_time_q;
    is_pressed_d   = is_pressed_q;
    long_rep_d     = long_rep_q;
    click_pend_d   = click_pend_q;
    res_vld        = 1'b0;
    res_gest       = GEST_SHORT;
    t_next         = time_now_q + 1'b1;
    div_next       = poll_div_q + 1'b1;
    press_el       = time_now_q - press_time_q;
    pend_el        = t_next - pending_time_q;

    if (in_action_q == ACTION_EDGE) begin
      if (!in_level_q) begin
        press_time_d = time_now_q;
        is_pressed_d = 1'b1;
        long_rep_d   = 1'b0;
      end else if (is_pressed_q) begin
        is_pressed_d = 1'b0;
        if (long_rep_q) begin
          res_vld  = 1'b1;
          res_gest = GEST_LEND;
        end else if (press_el < time_t'(long_ticks_q)) begin
          if (single_key_q) begin
            if (click_pend_q) begin
              click_pend_d = 1'b0;
              res_vld      = 1'b1;
              res_gest     = GEST_DOUBLE;
            end else begin
              click_pend_d   = 1'b1;
              pending_time_d = time_now_q;
            end
          end else begin
            res_vld  = 1'b1;
            res_gest = GEST_SHORT;
          end
        end
      end
    end else begin
      time_now_d = t_next;
      poll_div_d = div_next;
      press_el   = t_next - press_time_q;
      if (div_next >= poll_ticks_q) begin
        poll_div_d = '0;
        if (is_pressed_q && !long_rep_q) begin
          if (in_level_q) begin
            is_pressed_d = 1'b0;
          end else if (press_el >= time_t'(long_ticks_q)) begin
            long_rep_d = 1'b1;
            res_vld    = 1'b1;
            res_gest   = GEST_LSTART;
          end
        end
        if (!res_vld && single_key_q && click_pend_q && !is_pressed_d &&
            pend_el >= time_t'(dbl_ticks_q)) begin
          click_pend_d = 1'b0;
          res_vld      = 1'b1;
          res_gest     = GEST_SHORT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q     <= '0;
      poll_div_q     <= '0;
      press_time_q   <= '0;
      pending_time_q <= '0;
      is_pressed_q   <= 1'b0;
      long_rep_q     <= 1'b0;
      click_pend_q   <= 1'b0;
    end else if (advance) begin
      time_now_q     <= time_now_d;
      poll_div_q     <= poll_div_d;
      press_time_q   <= press_time_d;
      pending_time_q <= pending_time_d;
      is_pressed_q   <= is_pressed_d;
      long_rep_q     <= long_rep_d;
      click_pend_q   <= click_pend_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_gest_q <= res_gest;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_gest_q};

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_vld_q)
    else $error("input stage stalled while empty");

  a_pend_needs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(click_pend_q) |-> $past(single_key_q))
    else $error("click pending set outside single-key mode");

  a_double_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_vld && res_gest == GEST_DOUBLE) |=> !click_pend_q)
    else $error("double click left a pending click");

  a_lstart_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_vld && res_gest == GEST_LSTART) |=> long_rep_q)
    else $error("long start not recorded");

endmodule

[tb/sv/bgd_gesture_checker.sv]
// Checker: predicts button gestures from accepted stream and register transactions, compares results.
`timescale 1ns / 1ps

module bgd_gesture_checker
  import bgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,    // [0] pin_level, [7:1] zero
  input  logic        s_user_i,    // [0] action
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [7:0]  m_data_i,    // [1:0] gesture, [7:2] zero
  output int unsigned pending_o,
  output int unsigned failures_o
);

  ticks_t   long_limit;
  ticks_t   double_window;
  ticks_t   poll_period;
  logic     single_key;

  time_t    now_ticks;
  ticks_t   poll_count;
  time_t    press_start;
  logic     held;
  logic     long_sent;
  logic     click_waiting;
  time_t    click_start;

  gesture_e    expected_gestures[$];
  gesture_e    predicted;
  gesture_e    oldest;
  logic        produced;
  int unsigned failures;

  initial begin
    pending_o  = 0;
    failures_o = 0;
  end

  function automatic logic classify_item(input logic is_edge, input logic released,
                                         output gesture_e g);
    g = GEST_SHORT;
    if (is_edge) begin
      if (!released) begin
        press_start = now_ticks;
        held        = 1'b1;
        long_sent   = 1'b0;
        return 1'b0;
      end
      if (!held) return 1'b0;
      held = 1'b0;
      if (long_sent) begin
        g = GEST_LEND;
        return 1'b1;
      end
      if (time_t'(now_ticks - press_start) >= long_limit) return 1'b0;
      if (!single_key) begin
        g = GEST_SHORT;
        return 1'b1;
      end
      if (click_waiting) begin
        click_waiting = 1'b0;
        g = GEST_DOUBLE;
        return 1'b1;
      end
      click_waiting = 1'b1;
      click_start   = now_ticks;
      return 1'b0;
    end
    now_ticks  = now_ticks + 1'b1;
    poll_count = poll_count + 1'b1;
    if (poll_count < poll_period) return 1'b0;
    poll_count = '0;
    if (held && !long_sent) begin
      if (released) begin
        held = 1'b0;
      end else if (time_t'(now_ticks - press_start) >= long_limit) begin
        long_sent = 1'b1;
        g = GEST_LSTART;
        return 1'b1;
      end
    end
    if (single_key && click_waiting && !held &&
        time_t'(now_ticks - click_start) >= double_window) begin
      click_waiting = 1'b0;
      g = GEST_SHORT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_limit    = LONG_PRESS_RESET;
      double_window = DOUBLE_CLICK_RESET;
      poll_period   = POLL_PERIOD_RESET;
      single_key    = 1'b1;
      now_ticks     = '0;
      poll_count    = '0;
      press_start   = '0;
      held          = 1'b0;
      long_sent     = 1'b0;
      click_waiting = 1'b0;
      click_start   = '0;
      failures      = 0;
      expected_gestures.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_LONG_PRESS:   long_limit    = pwdata_i[15:0];
          REG_DOUBLE_CLICK: double_window = pwdata_i[15:0];
          REG_POLL_PERIOD:  poll_period   = pwdata_i[15:0];
          REG_SINGLE_KEY:   single_key    = pwdata_i[0];
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        if (expected_gestures.size() == 0) begin
          $error("gesture: expected none, actual %0d", m_data_i[1:0]);
          failures++;
        end else begin
          oldest = expected_gestures.pop_front();
          if (m_data_i[1:0] !== oldest) begin
            $error("gesture: expected %0d, actual %0d", oldest, m_data_i[1:0]);
            failures++;
          end
          if (m_data_i[7:2] !== 6'd0) begin
            $error("tdata padding: expected 0, actual %0h", m_data_i[7:2]);
            failures++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        produced = classify_item(s_user_i, s_data_i[0], predicted);
        if (produced) expected_gestures.push_back(predicted);
      end
    end
    pending_o  <= expected_gestures.size();
    failures_o <= failures;
  end

endmodule

[tb/sv/testbench.sv]
// Testbench top: drives button edges, ticks and register writes into the gesture detector.
`timescale 1ns / 1ps

module testbench;
  import bgd_pkg::*;

  localparam logic PRESSED  = 1'b0;
  localparam logic RELEASED = 1'b1;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = 4'd0;
  logic [31:0] pwdata   = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  int unsigned pending;
  int unsigned failures;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_done     = 0;
  int unsigned items_sent    = 0;
  ticks_t      long_cfg      = LONG_PRESS_RESET;
  ticks_t      dbl_cfg       = DOUBLE_CLICK_RESET;

  button_gesture_detector dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  bgd_gesture_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .s_valid_i  (s_tvalid),
    .s_ready_i  (s_tready),
    .s_data_i   (s_tdata),
    .s_user_i   (s_tuser),
    .m_valid_i  (m_tvalid),
    .m_ready_i  (m_tready),
    .m_data_i   (m_tdata),
    .pending_o  (pending),
    .failures_o (failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done++;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_item(input logic act, input logic lvl);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'd0, lvl};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned n, input logic lvl, input int unsigned flip_pct);
    repeat (n) send_item(ACTION_TICK, ($urandom_range(0, 99) < flip_pct) ? ~lvl : lvl);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input ticks_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LONG_PRESS) long_cfg = value;
    if (idx == REG_DOUBLE_CLICK) dbl_cfg = value;
  endtask

  function automatic ticks_t pick_ticks(input int unsigned small_max);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd1;
    if (r == 1) return 16'hFFFF;
    return ticks_t'($urandom_range(1, small_max));
  endfunction

  task automatic play_gesture();
    int unsigned hold_max;
    int unsigned gap_max;
    hold_max = (long_cfg > 40) ? 48 : long_cfg + 8;
    gap_max  = (dbl_cfg > 32) ? 40 : dbl_cfg + 8;
    send_item(ACTION_EDGE, PRESSED);
    send_ticks($urandom_range(0, hold_max), PRESSED, 4);
    send_item(ACTION_EDGE, RELEASED);
    send_ticks($urandom_range(0, gap_max), RELEASED, 4);
  endtask

  initial begin
    int unsigned phase_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_LONG_PRESS, 16'd4);
    write_reg(REG_DOUBLE_CLICK, 16'd3);
    write_reg(REG_POLL_PERIOD, 16'd3);
    send_ticks(2, RELEASED, 0);
    send_item(ACTION_EDGE, PRESSED);
    send_item(ACTION_TICK, PRESSED);
    send_item(ACTION_EDGE, RELEASED);
    send_item(ACTION_EDGE, PRESSED);
    send_item(ACTION_EDGE, RELEASED);
    send_item(ACTION_EDGE, PRESSED);
    send_item(ACTION_EDGE, RELEASED);
    send_ticks(4, RELEASED, 0);
    send_item(ACTION_EDGE, PRESSED);
    send_item(ACTION_EDGE, PRESSED);
    send_ticks(6, PRESSED, 0);
    send_item(ACTION_EDGE, RELEASED);
    send_item(ACTION_EDGE, RELEASED);
    send_item(ACTION_EDGE, PRESSED);
    send_ticks(3, RELEASED, 0);

    drain();
    write_reg(REG_POLL_PERIOD, 16'hFFFF);
    send_item(ACTION_EDGE, PRESSED);
    send_ticks(5, PRESSED, 0);
    send_item(ACTION_EDGE, RELEASED);
    send_item(ACTION_EDGE, PRESSED);
    send_item(ACTION_EDGE, RELEASED);
    drain();
    write_reg(REG_SINGLE_KEY, 16'd0);
    send_item(ACTION_EDGE, PRESSED);
    send_item(ACTION_EDGE, RELEASED);
    send_ticks(4, RELEASED, 0);
    drain();
    write_reg(REG_SINGLE_KEY, 16'd1);
    write_reg(REG_POLL_PERIOD, 16'd1);
    send_ticks(2, RELEASED, 0);

    for (int phase = 0; phase < 16; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_LONG_PRESS, 16'd1);
          write_reg(REG_DOUBLE_CLICK, 16'd1);
          write_reg(REG_POLL_PERIOD, 16'd1);
          write_reg(REG_SINGLE_KEY, 16'd1);
        end
        1: begin
          write_reg(REG_LONG_PRESS, 16'hFFFF);
          write_reg(REG_DOUBLE_CLICK, 16'hFFFF);
          write_reg(REG_POLL_PERIOD, 16'hFFFF);
          write_reg(REG_SINGLE_KEY, 16'd0);
        end
        default: begin
          write_reg(REG_LONG_PRESS, pick_ticks(40));
          write_reg(REG_DOUBLE_CLICK, pick_ticks(30));
          write_reg(REG_POLL_PERIOD, pick_ticks(8));
          write_reg(REG_SINGLE_KEY, ticks_t'($urandom_range(0, 1)));
        end
      endcase
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
        default: begin src_idle_pct = 8; snk_stall_pct = 8; end
      endcase
      if (phase == 4) hold_req++;
      phase_start = items_sent;
      while (items_sent - phase_start < 125) begin
        if ($urandom_range(0, 9) < 7) begin
          play_gesture();
        end else begin
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
